[design/scat_pkg.sv]
// ----------------------------------------------------------------------------
// scat_pkg: shared types and codes of the sparse coordinate accumulate table
// Entry layout, result bundle, function and status codes, table sizes.
// ----------------------------------------------------------------------------
package scat_pkg;

	localparam int CAPACITY = 256;
	localparam int MAX_DIM  = 1024;

	localparam int COORD_W = 11;
	localparam int VAL_W   = 32;
	localparam int FUNC_W  = 3;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_TRANS = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

	localparam logic [STAT_W-1:0] STAT_NEW     = 3'd0;
	localparam logic [STAT_W-1:0] STAT_MERGED  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd2;
	localparam logic [STAT_W-1:0] STAT_READ    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic [COORD_W-1:0]      row;
		logic [COORD_W-1:0]      col;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic [COORD_W-1:0]      row;
		logic [COORD_W-1:0]      col;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        count;
	} result_t;

endpackage

[design/scat_ram.sv]
// ----------------------------------------------------------------------------
// scat_ram: generic simple dual-port ram
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module scat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/scat_engine.sv]
// ----------------------------------------------------------------------------
// scat_engine: sequencer and entry store of the accumulate table
// Linear search over the sorted entries, read-modify-write merge, and a
// descending shift to open a slot for a new coordinate.
// ----------------------------------------------------------------------------
module scat_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [scat_pkg::FUNC_W-1:0]          in_func,
	input  logic [scat_pkg::COORD_W-1:0]         in_row,
	input  logic [scat_pkg::COORD_W-1:0]         in_col,
	input  logic signed [scat_pkg::VAL_W-1:0]    in_value,
	input  logic [scat_pkg::IDX_W-1:0]           in_index,
	input  logic                                 out_free,
	output logic                                 res_valid,
	output scat_pkg::result_t                    res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_SRCH  = 3'd2;
	localparam logic [2:0] S_ACC   = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_INS   = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;

	localparam int ENT_W = $bits(scat_pkg::entry_t);

	logic [2:0]                          state_q;
	logic [scat_pkg::FUNC_W-1:0]         func_q;
	logic [scat_pkg::COORD_W-1:0]        row_q;
	logic [scat_pkg::COORD_W-1:0]        col_q;
	logic signed [scat_pkg::VAL_W-1:0]   val_q;
	logic [scat_pkg::IDX_W-1:0]          idx_q;
	logic [scat_pkg::CNT_W-1:0]          held_q;
	logic [scat_pkg::CNT_W-1:0]          cnt_q;
	logic                                chk_v_q;
	logic [scat_pkg::IDX_W-1:0]          chk_q;
	logic [scat_pkg::CNT_W-1:0]          pos_q;
	logic                                found_q;
	logic signed [scat_pkg::VAL_W-1:0]   old_q;
	logic [scat_pkg::CNT_W-1:0]          sh_q;
	logic                                pend_v_q;
	logic [scat_pkg::IDX_W-1:0]          pend_q;

	logic                                wr_en;
	logic [scat_pkg::IDX_W-1:0]          wr_addr;
	scat_pkg::entry_t                    wr_entry;
	logic                                rd_en;
	logic [scat_pkg::IDX_W-1:0]          rd_addr;
	logic [ENT_W-1:0]                    rd_raw;
	scat_pkg::entry_t                    rd_entry;

	logic [2*scat_pkg::COORD_W-1:0]      key;
	logic [2*scat_pkg::COORD_W-1:0]      rd_key;
	logic                                hit;
	logic                                issue;
	logic                                bad_coord;
	logic                                idx_ok;
	logic signed [scat_pkg::VAL_W:0]     addend;
	logic signed [scat_pkg::VAL_W:0]     base;
	logic signed [scat_pkg::VAL_W+1:0]   sum_w;
	logic signed [scat_pkg::VAL_W-1:0]   sat_val;

	scat_ram #(
		.WIDTH(ENT_W),
		.DEPTH(scat_pkg::CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_entry = scat_pkg::entry_t'(rd_raw);
	assign key      = {row_q, col_q};
	assign rd_key   = {rd_entry.row, rd_entry.col};
	assign hit      = chk_v_q && (rd_key >= key);
	assign issue    = !hit && (cnt_q < held_q);
	assign idx_ok   = {1'b0, idx_q} < held_q;
	assign in_ready = (state_q == S_IDLE);

	assign bad_coord = (row_q == '0) || (col_q == '0) ||
		(row_q > scat_pkg::COORD_W'(scat_pkg::MAX_DIM)) ||
		(col_q > scat_pkg::COORD_W'(scat_pkg::MAX_DIM));

	// widen before negating so the most negative value saturates cleanly
	always_comb begin
		addend = (func_q == scat_pkg::FUNC_SUB) ? -{val_q[scat_pkg::VAL_W-1], val_q}
			: {val_q[scat_pkg::VAL_W-1], val_q};
		base   = found_q ? {old_q[scat_pkg::VAL_W-1], old_q} : '0;
		sum_w  = {base[scat_pkg::VAL_W], base} + {addend[scat_pkg::VAL_W], addend};
		if (sum_w[scat_pkg::VAL_W+1:scat_pkg::VAL_W-1] == 3'b000 ||
			sum_w[scat_pkg::VAL_W+1:scat_pkg::VAL_W-1] == 3'b111) begin
			sat_val = sum_w[scat_pkg::VAL_W-1:0];
		end else if (sum_w[scat_pkg::VAL_W+1]) begin
			sat_val = scat_pkg::VAL_MIN;
		end else begin
			sat_val = scat_pkg::VAL_MAX;
		end
	end

	// memory port control and result formation
	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = pos_q[scat_pkg::IDX_W-1:0];
		wr_entry.row   = row_q;
		wr_entry.col   = col_q;
		wr_entry.value = sat_val;
		rd_en          = 1'b0;
		rd_addr        = cnt_q[scat_pkg::IDX_W-1:0];
		res_valid      = 1'b0;
		res.status     = scat_pkg::STAT_EMPTY;
		res.row        = '0;
		res.col        = '0;
		res.value      = '0;
		res.count      = held_q;
		case (state_q)
			S_DISP: begin
				case (func_q)
					scat_pkg::FUNC_ADD, scat_pkg::FUNC_SUB, scat_pkg::FUNC_TRANS: begin
						if (bad_coord) begin
							res_valid  = out_free;
							res.status = scat_pkg::STAT_DROPPED;
						end
					end
					scat_pkg::FUNC_READ: begin
						rd_addr = idx_q;
						if (idx_ok) begin
							rd_en = 1'b1;
						end else begin
							res_valid = out_free;
						end
					end
					scat_pkg::FUNC_CLEAR: begin
						res_valid = out_free;
						res.count = '0;
					end
					default: begin
						res_valid = out_free;
					end
				endcase
			end
			S_SRCH: begin
				rd_en = issue;
			end
			S_ACC: begin
				if (found_q) begin
					wr_en      = out_free;
					res_valid  = out_free;
					res.status = scat_pkg::STAT_MERGED;
					res.value  = sat_val;
				end else if (held_q == scat_pkg::CNT_W'(scat_pkg::CAPACITY)) begin
					res_valid  = out_free;
					res.status = scat_pkg::STAT_DROPPED;
				end
			end
			S_SHIFT: begin
				wr_en    = pend_v_q;
				wr_addr  = pend_q;
				wr_entry = rd_entry;
				rd_en    = sh_q > pos_q;
				rd_addr  = scat_pkg::IDX_W'(sh_q - 1'b1);
			end
			S_INS: begin
				wr_en      = out_free;
				res_valid  = out_free;
				res.status = scat_pkg::STAT_NEW;
				res.value  = sat_val;
				res.count  = held_q + 1'b1;
			end
			S_READ: begin
				res_valid  = out_free;
				res.status = scat_pkg::STAT_READ;
				res.row    = rd_entry.row;
				res.col    = rd_entry.col;
				res.value  = rd_entry.value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			held_q   <= '0;
			chk_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (func_q)
						scat_pkg::FUNC_ADD, scat_pkg::FUNC_SUB, scat_pkg::FUNC_TRANS: begin
							if (bad_coord) begin
								if (out_free) begin
									state_q <= S_IDLE;
								end
							end else begin
								chk_v_q <= 1'b0;
								state_q <= S_SRCH;
							end
						end
						scat_pkg::FUNC_READ: begin
							if (idx_ok) begin
								state_q <= S_READ;
							end else if (out_free) begin
								state_q <= S_IDLE;
							end
						end
						scat_pkg::FUNC_CLEAR: begin
							if (out_free) begin
								held_q  <= '0;
								state_q <= S_IDLE;
							end
						end
						default: begin
							if (out_free) begin
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_SRCH: begin
					chk_v_q <= issue;
					if (hit || !issue) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (found_q || held_q == scat_pkg::CNT_W'(scat_pkg::CAPACITY)) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						pend_v_q <= 1'b0;
						state_q  <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					pend_v_q <= sh_q > pos_q;
					if (sh_q == pos_q) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (out_free) begin
						held_q  <= held_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			func_q <= in_func;
			row_q  <= (in_func == scat_pkg::FUNC_TRANS) ? in_col : in_row;
			col_q  <= (in_func == scat_pkg::FUNC_TRANS) ? in_row : in_col;
			val_q  <= in_value;
			idx_q  <= in_index;
		end
		if (state_q == S_DISP) begin
			cnt_q <= '0;
		end
		if (state_q == S_SRCH) begin
			chk_q <= cnt_q[scat_pkg::IDX_W-1:0];
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (hit) begin
				pos_q   <= {1'b0, chk_q};
				found_q <= (rd_key == key);
				old_q   <= rd_entry.value;
			end else if (!issue) begin
				pos_q   <= held_q;
				found_q <= 1'b0;
			end
		end
		if (state_q == S_ACC) begin
			sh_q <= held_q;
		end
		// move entry sh-1 up to sh, one read issued per cycle
		if (state_q == S_SHIFT && sh_q > pos_q) begin
			pend_q <= sh_q[scat_pkg::IDX_W-1:0];
			sh_q   <= sh_q - 1'b1;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= scat_pkg::CNT_W'(scat_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_ACC || state_q == S_SHIFT || state_q == S_INS))
		else $error("table write outside an update");

	a_shift_above_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && pend_v_q) |-> ({1'b0, pend_q} > pos_q))
		else $error("shift writes at or below the insert slot");

	a_held_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_q) |-> $past(res_valid))
		else $error("entry count changed without a result");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (held_q < scat_pkg::CNT_W'(scat_pkg::CAPACITY)))
		else $error("insert into a full table");

endmodule

[design/sparse_coordinate_accumulate_table.sv]
// ----------------------------------------------------------------------------
// sparse_coordinate_accumulate_table: sorted sparse matrix entry table
// Holds up to 256 (row, column, value) entries in sorted order and
// accumulates, reads or clears them one request at a time.
// ----------------------------------------------------------------------------
// usage
//  - input channel in_valid/in_ready carries one request: func, row_coord,
//    col_coord, entry_value, read_index; output channel out_valid/out_ready
//    returns exactly one result per request
//  - one request is worked on at a time; in_ready is high while the
//    sequencer is idle, even if a result still waits in the output register
//  - accumulate: a linear search reads one entry per cycle from the entry
//    ram, a new coordinate then shifts the later entries up one per cycle
//    through the single write port; search and shift together read each
//    entry once, but the one at the insert slot twice
//  - read passes the dispatch and read states to the output register,
//    clear and unused codes answer from the dispatch state
//  - a stalled receiver holds the output register; a finished request then
//    waits in the sequencer until the register frees, so nothing is lost
//  - reset empties the table at once (count to zero); ram contents are not
//    cleared, as only positions below the count are ever read
// ----------------------------------------------------------------------------
module sparse_coordinate_accumulate_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [scat_pkg::FUNC_W-1:0]        func,
	input  logic [scat_pkg::COORD_W-1:0]       row_coord,
	input  logic [scat_pkg::COORD_W-1:0]       col_coord,
	input  logic signed [scat_pkg::VAL_W-1:0]  entry_value,
	input  logic [scat_pkg::IDX_W-1:0]         read_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [scat_pkg::STAT_W-1:0]        status,
	output logic [scat_pkg::COORD_W-1:0]       out_row,
	output logic [scat_pkg::COORD_W-1:0]       out_col,
	output logic signed [scat_pkg::VAL_W-1:0]  out_value,
	output logic [scat_pkg::CNT_W-1:0]         entry_count
);

	logic              out_valid_q;
	logic              out_free;
	logic              res_valid;
	scat_pkg::result_t res;
	scat_pkg::result_t res_q;

	assign out_free = !out_valid_q || out_ready;

	scat_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_func  (func),
		.in_row   (row_coord),
		.in_col   (col_coord),
		.in_value (entry_value),
		.in_index (read_index),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign out_row     = res_q.row;
	assign out_col     = res_q.col;
	assign out_value   = res_q.value;
	assign entry_count = res_q.count;

endmodule
